FILE: src/acpu_pkg.sv
// Package with opcodes, status codes and sizing constants of the accumulator execute block.
`default_nettype none
package acpu_pkg;
	localparam int DataWordsDefault    = 128;
	localparam int ProgramWordsDefault = 256;
	localparam int OpW   = 8;
	localparam int ArgW  = 8;
	localparam int PcW   = 8;
	localparam int AccW  = 32;
	localparam int StatW = 2;

	typedef enum logic [7:0] {
		OP_LOAD_M = 8'd0, OP_LOAD_V = 8'd1, OP_STORE = 8'd2, OP_ADD = 8'd3,
		OP_SUB = 8'd4, OP_MUL = 8'd5, OP_DIV = 8'd6, OP_INC = 8'd7,
		OP_DEC = 8'd8, OP_AND = 8'd9, OP_OR = 8'd10, OP_NOT = 8'd11,
		OP_JMP = 8'd12, OP_JZ = 8'd13, OP_JNZ = 8'd14, OP_JG = 8'd15,
		OP_JL = 8'd16, OP_JGE = 8'd17, OP_JLE = 8'd18, OP_HLT = 8'd19
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_HALT = 2'd1, ST_UNKNOWN = 2'd2, ST_DIV0 = 2'd3
	} status_t;

	typedef struct packed {
		logic [AccW-1:0] quotient;
	} div_res_t;
endpackage
`default_nettype wire

FILE: src/acpu_if.sv
// Valid/ready channel interface carrying a generic payload.
`default_nettype none
interface acpu_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/acpu_div.sv
// Iterative signed divider, one quotient bit per cycle.
`default_nettype none
module acpu_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [acpu_pkg::AccW-1:0] dividend,
	input  wire logic [acpu_pkg::AccW-1:0] divisor,
	output      logic                      done,
	output      acpu_pkg::div_res_t        result
);
	localparam int W = acpu_pkg::AccW;
	logic [W-1:0]         rem_q, quo_q, den_q;
	logic [$clog2(W):0]   cnt_q;
	logic                 neg_q, busy_q;
	logic [W:0]           trial;
	logic [W-1:0]         shifted;

	always_comb begin
		shifted = {rem_q[W-2:0], quo_q[W-1]};
		trial   = {1'b0, shifted} - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				quo_q  <= dividend[W-1] ? -dividend : dividend;
				den_q  <= divisor[W-1] ? -divisor : divisor;
				neg_q  <= dividend[W-1] ^ divisor[W-1];
			end else if (busy_q) begin
				if (trial[W]) begin
					rem_q <= shifted;
					quo_q <= {quo_q[W-2:0], 1'b0};
				end else begin
					rem_q <= trial[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b1};
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(W)+1)'(W-1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign result.quotient = neg_q ? -quo_q : quo_q;
endmodule
`default_nettype wire

FILE: src/accumulator_cpu_execute_top.sv
// Top level of the accumulator machine execute block.
// Usage: the host sends one instruction transaction (opcode, operand) on the
// input channel and receives one result transaction (next_pc, acc_value,
// status) on the output channel; it then fetches the next instruction at
// next_pc.
// Timing: the data memory word is read at the edge that accepts the
// instruction (synchronous read, addressed straight from the input
// operand). The instruction executes in the next cycle and its result is
// staged; it then moves into the output register once that register is
// free, and the next instruction can then be accepted. A divide runs the
// one-bit-per-cycle divider first. Multiplication is registered before use.
// Reset: accumulator and pc clear at once, then a clearing pass writes zero
// to every data word, one per cycle, during which no transaction is accepted.
// Stall: the result sits in the output register until the receiver takes it;
// the next instruction is accepted meanwhile, executes, and its result waits
// in the staging register until the output register is free.
`default_nettype none
module accumulator_cpu_execute_top #(
	parameter int DATA_WORDS    = acpu_pkg::DataWordsDefault,
	parameter int PROGRAM_WORDS = acpu_pkg::ProgramWordsDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	acpu_if.sink     in_ch,
	acpu_if.source   out_ch
);
	localparam int AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
	localparam int PW = (PROGRAM_WORDS > 1) ? $clog2(PROGRAM_WORDS) : 1;
	localparam int W  = acpu_pkg::AccW;

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_MUL, S_DIV, S_OUT} state_t;
	state_t state_q;

	logic [W-1:0]    mem [DATA_WORDS];
	logic [W-1:0]    rd_s1;
	logic [AW-1:0]   clr_q;
	logic [7:0]      op_q, arg_q;
	logic [W-1:0]    acc_q, prod_q;
	logic [acpu_pkg::PcW-1:0] pc_q;
	logic            div_start, div_done;
	acpu_pkg::div_res_t div_res;
	logic [AW-1:0]   addr;
	logic            we;
	logic [W-1:0]    wdata;
	// Staged result of the instruction in flight, waiting for the output register.
	logic [acpu_pkg::PcW-1:0] res_pc_q;
	logic [W-1:0]             res_acc_q;
	acpu_pkg::status_t        res_st_q;

	// While idle the read is addressed by the offered operand, so the word is
	// ready in the cycle after acceptance.
	assign addr = (state_q == S_CLEAR) ? clr_q :
		(state_q == S_IDLE) ? in_ch.data.operand[AW-1:0] : arg_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rd_s1 <= mem[addr];
	end

	acpu_div u_div (.clk, .arst_n, .start(div_start), .dividend(acc_q),
		.divisor(rd_s1), .done(div_done), .result(div_res));

	assign in_ch.ready = (state_q == S_IDLE);

	logic [W-1:0] n_acc;
	logic [acpu_pkg::PcW-1:0] n_pc, pc_inc, tgt;
	acpu_pkg::status_t n_st;
	logic neg, zero;

	always_comb begin
		pc_inc = acpu_pkg::PcW'((PW+1)'(pc_q) + (PW+1)'(1)) & acpu_pkg::PcW'(PROGRAM_WORDS-1);
		tgt    = arg_q & acpu_pkg::PcW'(PROGRAM_WORDS-1);
		neg    = acc_q[W-1];
		zero   = (acc_q == '0);
		n_acc  = acc_q;
		n_pc   = pc_inc;
		n_st   = acpu_pkg::ST_OK;
		we     = (state_q == S_CLEAR);
		wdata  = (state_q == S_CLEAR) ? '0 : acc_q;
		div_start = 1'b0;
		if (state_q == S_READ) begin
			unique case (op_q)
				acpu_pkg::OP_LOAD_M: n_acc = rd_s1;
				acpu_pkg::OP_LOAD_V: n_acc = {{(W-8){arg_q[7]}}, arg_q};
				acpu_pkg::OP_STORE:  we = 1'b1;
				acpu_pkg::OP_ADD:    n_acc = acc_q + rd_s1;
				acpu_pkg::OP_SUB:    n_acc = acc_q - rd_s1;
				acpu_pkg::OP_MUL:    ;
				acpu_pkg::OP_DIV: begin
					if (rd_s1 == '0) begin
						n_st = acpu_pkg::ST_DIV0;
						n_pc = pc_q;
					end else div_start = 1'b1;
				end
				acpu_pkg::OP_INC:    n_acc = acc_q + 1'b1;
				acpu_pkg::OP_DEC:    n_acc = acc_q - 1'b1;
				acpu_pkg::OP_AND:    n_acc = W'(!zero && rd_s1 != '0);
				acpu_pkg::OP_OR:     n_acc = W'(!zero || rd_s1 != '0);
				acpu_pkg::OP_NOT:    n_acc = W'(zero);
				acpu_pkg::OP_JMP:    n_pc = tgt;
				acpu_pkg::OP_JZ:     if (zero) n_pc = tgt;
				acpu_pkg::OP_JNZ:    if (!zero) n_pc = tgt;
				acpu_pkg::OP_JG:     if (!zero && !neg) n_pc = tgt;
				acpu_pkg::OP_JL:     if (neg) n_pc = tgt;
				acpu_pkg::OP_JGE:    if (!neg) n_pc = tgt;
				acpu_pkg::OP_JLE:    if (zero || neg) n_pc = tgt;
				acpu_pkg::OP_HLT: begin
					n_st = acpu_pkg::ST_HALT;
					n_pc = pc_q;
				end
				default: begin
					n_st = acpu_pkg::ST_UNKNOWN;
					n_pc = pc_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_READ && op_q == acpu_pkg::OP_MUL) prod_q <= acc_q * rd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			acc_q        <= '0;
			pc_q         <= '0;
			out_ch.valid <= 1'b0;
		end else begin
			// The output register loads when it is empty or being emptied.
			if (state_q == S_OUT && (!out_ch.valid || out_ch.ready)) out_ch.valid <= 1'b1;
			else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DATA_WORDS-1)) state_q <= S_IDLE;
				end
				S_IDLE: if (in_ch.valid) begin
					op_q    <= in_ch.data.opcode;
					arg_q   <= in_ch.data.operand;
					state_q <= S_READ;
				end
				S_READ: begin
					if (op_q == acpu_pkg::OP_MUL) state_q <= S_MUL;
					else if (div_start) state_q <= S_DIV;
					else begin
						acc_q     <= n_acc;
						pc_q      <= n_pc;
						res_pc_q  <= n_pc;
						res_acc_q <= n_acc;
						res_st_q  <= n_st;
						state_q   <= S_OUT;
					end
				end
				S_MUL: begin
					acc_q     <= prod_q;
					pc_q      <= pc_inc;
					res_pc_q  <= pc_inc;
					res_acc_q <= prod_q;
					res_st_q  <= acpu_pkg::ST_OK;
					state_q   <= S_OUT;
				end
				S_DIV: if (div_done) begin
					acc_q     <= div_res.quotient;
					pc_q      <= pc_inc;
					res_pc_q  <= pc_inc;
					res_acc_q <= div_res.quotient;
					res_st_q  <= acpu_pkg::ST_OK;
					state_q   <= S_OUT;
				end
				S_OUT: if (!out_ch.valid || out_ch.ready) begin
					out_ch.data.next_pc   <= res_pc_q;
					out_ch.data.acc_value <= res_acc_q;
					out_ch.data.status    <= res_st_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: src/acpu_checker.sv
// Port-level checker for the accumulator execute block, with its bind.
`default_nettype none
module acpu_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] status
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(status)) else $error("result changed while waiting");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("second accept");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid || !$rose(out_valid))
		else $error("result too early");
endmodule

bind accumulator_cpu_execute_top acpu_checker u_chk (
	.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .status(out_ch.data.status));
`default_nettype wire
